// ===== rtl/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: shared package
// Field widths, calendar constants and the month tables used by the
// converter and its channel interfaces.
// ----------------------------------------------------------------------------
package esc_pkg;

    // Field widths
    localparam int ESC_SECS_W    = 32;
    localparam int ESC_YEAR_W    = 12;
    localparam int ESC_MONTH_W   = 4;
    localparam int ESC_DAY_W     = 5;
    localparam int ESC_HOUR_W    = 5;
    localparam int ESC_MINUTE_W  = 6;
    localparam int ESC_SECOND_W  = 6;
    localparam int ESC_WEEKDAY_W = 3;

    // Calendar constants
    localparam int ESC_SECS_PER_DAY  = 86400;
    localparam int ESC_SECS_PER_HOUR = 3600;
    localparam int ESC_SECS_PER_MIN  = 60;
    localparam int ESC_DAYS_PER_WEEK = 7;
    localparam int ESC_EPOCH_YEAR    = 1970;
    localparam int ESC_LAST_YEAR     = 2099;
    localparam int ESC_BASE_YEAR     = 1900;
    localparam int ESC_COMMON_DAYS   = 365;
    localparam int ESC_LEAP_DAYS     = 366;
    localparam int ESC_EPOCH_WEEKDAY = 4;

    // Days in a month of a common year; index 0 is January.
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        begin
            unique case (m)
                4'd1:                         len = 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10:      len = 5'd30;
                default:                      len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // Month offsets of the weekday formula; index 0 is January.
    function automatic logic [2:0] month_offset(input logic [3:0] m);
        logic [2:0] off;
        begin
            unique case (m)
                4'd0:  off = 3'd0;
                4'd1:  off = 3'd3;
                4'd2:  off = 3'd3;
                4'd3:  off = 3'd6;
                4'd4:  off = 3'd1;
                4'd5:  off = 3'd4;
                4'd6:  off = 3'd6;
                4'd7:  off = 3'd2;
                4'd8:  off = 3'd5;
                4'd9:  off = 3'd0;
                4'd10: off = 3'd3;
                4'd11: off = 3'd5;
                default: off = 3'd0;
            endcase
            return off;
        end
    endfunction

endpackage

// ===== rtl/esc_in_if.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: input channel
// Valid/ready channel that carries one seconds count per transfer.
// ----------------------------------------------------------------------------
interface esc_in_if;
    logic                           valid;
    logic                           ready;
    logic [esc_pkg::ESC_SECS_W-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// ===== rtl/esc_out_if.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: output channel
// Valid/ready channel that carries one calendar result per transfer.
// ----------------------------------------------------------------------------
interface esc_out_if;
    logic                              valid;
    logic                              ready;
    logic [esc_pkg::ESC_YEAR_W-1:0]    year_out;
    logic [esc_pkg::ESC_MONTH_W-1:0]   month_out;
    logic [esc_pkg::ESC_DAY_W-1:0]     day_out;
    logic [esc_pkg::ESC_HOUR_W-1:0]    hour_out;
    logic [esc_pkg::ESC_MINUTE_W-1:0]  minute_out;
    logic [esc_pkg::ESC_SECOND_W-1:0]  second_out;
    logic [esc_pkg::ESC_WEEKDAY_W-1:0] weekday_out;
    logic                              out_of_range;

    modport source (output valid, output year_out, output month_out, output day_out,
                    output hour_out, output minute_out, output second_out,
                    output weekday_out, output out_of_range, input ready);
    modport sink   (input valid, input year_out, input month_out, input day_out,
                    input hour_out, input minute_out, input second_out,
                    input weekday_out, input out_of_range, output ready);
endinterface

// ===== rtl/epoch_seconds_to_calendar_unit.sv =====
// Steps from input transfer to result valid: whole days, then hours, minutes
// and seconds, the year walk, the month walk, the weekday load and remainder,
// and the load of the output register.
// A new item is taken only in idle, once the last is through; ready returns the cycle after the
// result is loaded, and a stalled output holds the converter before that load.
// Reset (rst_n low, asynchronous) returns to idle with no result pending.
// ----------------------------------------------------------------------------
// Epoch seconds to calendar converter
// Turns a seconds count since 1970-01-01 into date, time of day and weekday
// with one shared compare/subtract unit driven by a small sequencer.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit (
    input  logic       clk,
    input  logic       rst_n,
    esc_in_if.sink     in_item,
    esc_out_if.source  out_item
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DAY,
        S_HOUR,
        S_MIN,
        S_YEAR,
        S_MONTH,
        S_WLOAD,
        S_WDAY,
        S_HOLD
    } state_t;

    state_t state_reg;

    // Working registers
    logic [31:0] acc_reg;
    logic [3:0]  k_reg;
    logic [15:0] q_reg;
    logic [15:0] days_reg;
    logic [11:0] year_reg;
    logic [1:0]  m4_reg;
    logic [6:0]  m100_reg;
    logic [8:0]  m400_reg;
    logic [3:0]  m_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [2:0]  weekday_reg;
    logic        oor_reg;

    // Output registers
    logic        out_valid_reg;
    logic [11:0] year_out_reg;
    logic [3:0]  month_out_reg;
    logic [4:0]  day_out_reg;
    logic [4:0]  hour_out_reg;
    logic [5:0]  minute_out_reg;
    logic [5:0]  second_out_reg;
    logic [2:0]  weekday_out_reg;
    logic        oor_out_reg;

    logic        leap;
    logic [4:0]  mlen;
    logic [31:0] operand_b;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] acc_step;
    logic [7:0]  yl;
    logic        wd_adj;
    logic [9:0]  wsum;
    logic        oor;

    // Gregorian leap test from the running year residues.
    assign leap = (m4_reg == 2'd0) && ((m100_reg != 7'd0) || (m400_reg == 9'd0));

    // Length of the current month, with a 29-day February in leap years.
    always_comb
    begin
        mlen = esc_pkg::month_len(m_reg);
        if ((m_reg == 4'd1) && leap)
        begin
            mlen = 5'd29;
        end
    end

    // Subtrahend of the shared unit for each phase.
    always_comb
    begin
        unique case (state_reg)
            S_DAY:   operand_b = 32'(esc_pkg::ESC_SECS_PER_DAY) << k_reg;
            S_HOUR:  operand_b = 32'(esc_pkg::ESC_SECS_PER_HOUR) << k_reg;
            S_MIN:   operand_b = 32'(esc_pkg::ESC_SECS_PER_MIN) << k_reg;
            S_YEAR:  operand_b = leap ? 32'(esc_pkg::ESC_LEAP_DAYS)
                                      : 32'(esc_pkg::ESC_COMMON_DAYS);
            S_MONTH: operand_b = {27'd0, mlen};
            S_WDAY:  operand_b = 32'(esc_pkg::ESC_DAYS_PER_WEEK) << k_reg;
            default: operand_b = 32'd0;
        endcase
    end

    // Shared compare and subtract unit.
    assign diff     = {1'b0, acc_reg} - {1'b0, operand_b};
    assign ge       = ~diff[32];
    assign acc_step = ge ? diff[31:0] : acc_reg;

    // Weekday table formula, valid for years up to 2099.
    assign yl     = 8'(year_reg - 12'(esc_pkg::ESC_BASE_YEAR));
    assign wd_adj = (yl[1:0] == 2'b00) && (m_reg < 4'd2);
    assign wsum   = 10'(yl) + 10'(yl[7:2]) + 10'(day_reg)
                  + 10'(esc_pkg::month_offset(m_reg)) - 10'(wd_adj);
    assign oor    = year_reg > 12'(esc_pkg::ESC_LAST_YEAR);

    assign in_item.ready = (state_reg == S_IDLE);

    // Sequencer, working registers and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            acc_reg         <= '0;
            k_reg           <= '0;
            q_reg           <= '0;
            days_reg        <= '0;
            year_reg        <= '0;
            m4_reg          <= '0;
            m100_reg        <= '0;
            m400_reg        <= '0;
            m_reg           <= '0;
            month_reg       <= '0;
            day_reg         <= '0;
            hour_reg        <= '0;
            minute_reg      <= '0;
            second_reg      <= '0;
            weekday_reg     <= '0;
            oor_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            year_out_reg    <= '0;
            month_out_reg   <= '0;
            day_out_reg     <= '0;
            hour_out_reg    <= '0;
            minute_out_reg  <= '0;
            second_out_reg  <= '0;
            weekday_out_reg <= '0;
            oor_out_reg     <= 1'b0;
        end
        else
        begin
            // A result is loaded from the sequencer or leaves on an output transfer.
            priority if ((state_reg == S_HOLD) && (!out_valid_reg || out_item.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_item.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_item.valid)
                    begin
                        acc_reg   <= in_item.epoch_seconds;
                        k_reg     <= 4'd15;
                        state_reg <= S_DAY;
                    end
                end

                // Whole days: restoring division by 86400.
                S_DAY:
                begin
                    acc_reg <= acc_step;
                    q_reg   <= {q_reg[14:0], ge};
                    if (k_reg == 4'd0)
                    begin
                        days_reg  <= {q_reg[14:0], ge};
                        k_reg     <= 4'd4;
                        state_reg <= S_HOUR;
                    end
                    else
                    begin
                        k_reg <= k_reg - 4'd1;
                    end
                end

                // Hours from the time of day.
                S_HOUR:
                begin
                    acc_reg <= acc_step;
                    q_reg   <= {q_reg[14:0], ge};
                    if (k_reg == 4'd0)
                    begin
                        hour_reg  <= {q_reg[3:0], ge};
                        k_reg     <= 4'd5;
                        state_reg <= S_MIN;
                    end
                    else
                    begin
                        k_reg <= k_reg - 4'd1;
                    end
                end

                // Minutes and seconds; then set up the year walk.
                S_MIN:
                begin
                    q_reg <= {q_reg[14:0], ge};
                    if (k_reg == 4'd0)
                    begin
                        minute_reg <= {q_reg[4:0], ge};
                        second_reg <= acc_step[5:0];
                        acc_reg    <= {16'd0, days_reg};
                        year_reg   <= 12'(esc_pkg::ESC_EPOCH_YEAR);
                        m4_reg     <= 2'(esc_pkg::ESC_EPOCH_YEAR % 4);
                        m100_reg   <= 7'(esc_pkg::ESC_EPOCH_YEAR % 100);
                        m400_reg   <= 9'(esc_pkg::ESC_EPOCH_YEAR % 400);
                        state_reg  <= S_YEAR;
                    end
                    else
                    begin
                        acc_reg <= acc_step;
                        k_reg   <= k_reg - 4'd1;
                    end
                end

                // One year per cycle while a whole year remains.
                S_YEAR:
                begin
                    if (ge)
                    begin
                        acc_reg  <= diff[31:0];
                        year_reg <= year_reg + 12'd1;
                        m4_reg   <= m4_reg + 2'd1;
                        m100_reg <= (m100_reg == 7'd99) ? 7'd0 : m100_reg + 7'd1;
                        m400_reg <= (m400_reg == 9'd399) ? 9'd0 : m400_reg + 9'd1;
                    end
                    else
                    begin
                        m_reg     <= 4'd0;
                        state_reg <= S_MONTH;
                    end
                end

                // One month per cycle while a whole month remains.
                S_MONTH:
                begin
                    if ((m_reg == 4'd11) || !ge)
                    begin
                        month_reg <= m_reg + 4'd1;
                        day_reg   <= acc_reg[4:0] + 5'd1;
                        state_reg <= S_WLOAD;
                    end
                    else
                    begin
                        acc_reg <= diff[31:0];
                        m_reg   <= m_reg + 4'd1;
                    end
                end

                // Pick the weekday dividend: table sum in range, day count beyond.
                S_WLOAD:
                begin
                    oor_reg   <= oor;
                    acc_reg   <= oor ? 32'(days_reg) + 32'(esc_pkg::ESC_EPOCH_WEEKDAY)
                                     : 32'(wsum);
                    k_reg     <= 4'd12;
                    state_reg <= S_WDAY;
                end

                // Remainder modulo 7 gives the weekday.
                S_WDAY:
                begin
                    acc_reg <= acc_step;
                    if (k_reg == 4'd0)
                    begin
                        weekday_reg <= acc_step[2:0];
                        state_reg   <= S_HOLD;
                    end
                    else
                    begin
                        k_reg <= k_reg - 4'd1;
                    end
                end

                // Move the result to the output once the slot is free.
                S_HOLD:
                begin
                    if (!out_valid_reg || out_item.ready)
                    begin
                        year_out_reg    <= year_reg;
                        month_out_reg   <= month_reg;
                        day_out_reg     <= day_reg;
                        hour_out_reg    <= hour_reg;
                        minute_out_reg  <= minute_reg;
                        second_out_reg  <= second_reg;
                        weekday_out_reg <= weekday_reg;
                        oor_out_reg     <= oor_reg;
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output channel
    assign out_item.valid        = out_valid_reg;
    assign out_item.year_out     = year_out_reg;
    assign out_item.month_out    = month_out_reg;
    assign out_item.day_out      = day_out_reg;
    assign out_item.hour_out     = hour_out_reg;
    assign out_item.minute_out   = minute_out_reg;
    assign out_item.second_out   = second_out_reg;
    assign out_item.weekday_out  = weekday_out_reg;
    assign out_item.out_of_range = oor_out_reg;

endmodule
